[hw/rtl/keyframe_track_sampler_unit_defines.svh]
// assertion macros for the keyframe track sampler checker
// no dependencies; the using scope must provide clk and rst_n
`ifndef KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kts_pkg.sv]
// shared types and constants for the keyframe track sampler
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package kts_pkg;

    // sizes
    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_COUNT_W  = 7;
    localparam int TIME_W       = 32;
    localparam int VAL_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int LOWER_W      = 6;
    localparam int BLEND_W      = 17;
    localparam int FRAC_W       = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam int DIV_STEP_W   = 6;

    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'h10000;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 1'b1;

    // divider step counts
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_MOD  = 6'd32;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_FRAC = 6'd16;

    // vector component select for the mixer
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic [SLOT_W-1:0]        key_index;
        logic [TIME_W-1:0]        time_req;
        logic signed [VAL_W-1:0]  value_x;
        logic signed [VAL_W-1:0]  value_y;
        logic signed [VAL_W-1:0]  value_z;
    } kts_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_x;
        logic signed [VAL_W-1:0]  out_y;
        logic signed [VAL_W-1:0]  out_z;
        logic [LOWER_W-1:0]       lower_key;
        logic [BLEND_W-1:0]       blend;
        logic                     empty_track;
    } kts_out_t;

    // one stored key
    typedef struct packed {
        logic [TIME_W-1:0]        key_time;
        logic signed [VAL_W-1:0]  val_x;
        logic signed [VAL_W-1:0]  val_y;
        logic signed [VAL_W-1:0]  val_z;
    } kts_key_t;

    typedef struct packed {
        logic                     start;
        logic [DIV_STEP_W-1:0]    steps;
        logic [TIME_W-1:0]        rem_init;
        logic [TIME_W-1:0]        quo_init;
        logic [TIME_W-1:0]        divisor;
    } kts_div_req_t;

    typedef struct packed {
        logic                     done;
        logic [TIME_W-1:0]        quotient;
        logic [TIME_W-1:0]        remainder;
    } kts_div_rsp_t;

    typedef struct packed {
        logic                     done;
        logic signed [VAL_W-1:0]  res_x;
        logic signed [VAL_W-1:0]  res_y;
        logic signed [VAL_W-1:0]  res_z;
    } kts_mix_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_HINT0,
        ST_HINT1,
        ST_HINT2,
        ST_HINT3,
        ST_SRCH_ISSUE,
        ST_SRCH_CMP,
        ST_RESOLVE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_DIFF,
        ST_ABS,
        ST_BLEND,
        ST_DIV_WAIT,
        ST_MIX_GO,
        ST_MIX_WAIT,
        ST_DONE
    } kts_state_t;

endpackage

[hw/rtl/kts_key_mem.sv]
// key store: time and x, y, z of every key, one write and one read port
// depends on kts_pkg
`timescale 1ns / 1ps

module kts_key_mem #(
    parameter int  MAX_KEYS = kts_pkg::MAX_KEYS_DEF,
    localparam int AW       = $clog2(MAX_KEYS)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  kts_pkg::kts_key_t wdata,
    input  logic [AW-1:0]    raddr,
    output kts_pkg::kts_key_t rdata
);
    import kts_pkg::*;

    kts_key_t key_mem [MAX_KEYS];
    kts_key_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= key_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/kts_div_unit.sv]
// shared shift-subtract divider, one quotient bit per cycle
// serves the time wrap and the blend factor; depends on kts_pkg
`timescale 1ns / 1ps

module kts_div_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kts_pkg::kts_div_req_t req,
    output kts_pkg::kts_div_rsp_t rsp
);
    import kts_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]     dvsr_reg, dvsr_next;
    logic [TIME_W:0]       trial;
    logic [TIME_W:0]       diff;
    logic                  fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = req.rem_init;
            quo_next  = req.quo_init;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next = {quo_reg[TIME_W-2:0], fits};
            cnt_next = cnt_reg - DIV_STEP_W'(1);
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[hw/rtl/kts_mix_unit.sv]
// linear mix a + floor((b - a) * f / 65536) for x, y, z through one multiplier
// three-stage pipeline fed one component per cycle; depends on kts_pkg
`timescale 1ns / 1ps

module kts_mix_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  kts_pkg::kts_key_t      key_a,
    input  kts_pkg::kts_key_t      key_b,
    input  logic [kts_pkg::BLEND_W-1:0] factor,
    output kts_pkg::kts_mix_rsp_t  rsp
);
    import kts_pkg::*;

    localparam int PROD_W = VAL_W + BLEND_W + 2;

    logic                       issuing_reg, issuing_next;
    logic [1:0]                 sel_reg, sel_next;
    logic                       s1_v_reg, s2_v_reg, done_reg;
    logic [1:0]                 s1_sel_reg, s2_sel_reg;
    logic signed [VAL_W-1:0]    s1_a_reg, s2_a_reg;
    logic signed [VAL_W:0]      s1_diff_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic signed [VAL_W-1:0]    res_x_reg, res_y_reg, res_z_reg;
    logic signed [VAL_W-1:0]    comp_a, comp_b;
    logic signed [BLEND_W:0]    factor_s;
    logic signed [PROD_W-1:0]   prod;
    logic [VAL_W-1:0]           mixed;

    // component select for the issue stage
    always_comb
    begin
        case (sel_reg)
            COMP_X:
            begin
                comp_a = key_a.val_x;
                comp_b = key_b.val_x;
            end
            COMP_Y:
            begin
                comp_a = key_a.val_y;
                comp_b = key_b.val_y;
            end
            COMP_Z:
            begin
                comp_a = key_a.val_z;
                comp_b = key_b.val_z;
            end
            default:
            begin
                comp_a = key_a.val_x;
                comp_b = key_b.val_x;
            end
        endcase
    end

    // issue sequencing
    always_comb
    begin
        issuing_next = issuing_reg;
        sel_next     = sel_reg;
        if (start)
        begin
            issuing_next = 1'b1;
            sel_next     = COMP_X;
        end
        else if (issuing_reg)
        begin
            sel_next = sel_reg + 2'd1;
            if (sel_reg == COMP_Z)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    // product and floor shift: the arithmetic shift by 16 keeps bits 47..16
    assign factor_s = $signed({1'b0, factor});
    assign prod     = s1_diff_reg * factor_s;
    assign mixed    = s2_a_reg + s2_prod_reg[VAL_W+FRAC_W-1:FRAC_W];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            sel_reg     <= COMP_X;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            sel_reg     <= sel_next;
            s1_v_reg    <= issuing_reg;
            s2_v_reg    <= s1_v_reg;
            done_reg    <= s2_v_reg && (s2_sel_reg == COMP_Z);
        end
    end

    // pipeline stages and result capture
    always_ff @(posedge clk)
    begin
        s1_sel_reg  <= sel_reg;
        s1_a_reg    <= comp_a;
        s1_diff_reg <= {comp_b[VAL_W-1], comp_b} - {comp_a[VAL_W-1], comp_a};
        s2_sel_reg  <= s1_sel_reg;
        s2_a_reg    <= s1_a_reg;
        s2_prod_reg <= prod;
        if (s2_v_reg)
        begin
            case (s2_sel_reg)
                COMP_X:  res_x_reg <= mixed;
                COMP_Y:  res_y_reg <= mixed;
                COMP_Z:  res_z_reg <= mixed;
                default: res_x_reg <= mixed;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.res_x = res_x_reg;
    assign rsp.res_y = res_y_reg;
    assign rsp.res_z = res_z_reg;

endmodule

[hw/rtl/keyframe_track_sampler_unit.sv]
// Keyframe track sampler: stores up to MAX_KEYS time-sorted 3-vector keys and
// returns the piecewise-linear value at a requested time. A load item writes one
// key and gives no result. A sample item gives one result: on an empty track it
// goes straight to the result, for a single key it reads that key, otherwise it
// passes through the accept, the time wrap (only when the duration is nonzero),
// the hint check, a binary search of at most ceil(log2(n+1)) steps (skipped on a
// hint hit), the key reads, the blend setup, the blend divide (only when
// 0 < f < 1), the mix and the result. Work is serialised by the one
// shift-subtract divider (32 steps for the wrap, 16 for the blend), the single
// read port of the key memory and the shared multiplier doing x, y, z in turn.
// The input is not ready while a sample is in progress; a finished result
// waits in the output register while the next item is taken. Key slots that
// were never loaded read back undefined. Configuration must be written only
// while idle; the block itself does not enforce this.
// depends on kts_pkg, kts_key_mem, kts_div_unit, kts_mix_unit
`timescale 1ns / 1ps

module keyframe_track_sampler_unit #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  kts_pkg::kts_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output kts_pkg::kts_out_t                out_data,
    input  logic                             cfg_we,
    input  logic [kts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import kts_pkg::*;

    localparam int AW      = $clog2(MAX_KEYS);
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int CMP_W   = (CNT_W > KEY_COUNT_W) ? CNT_W : KEY_COUNT_W;
    localparam int SLOTC_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    kts_state_t               state_reg, state_next;
    logic [KEY_COUNT_W-1:0]   key_count_reg, key_count_next;
    logic [TIME_W-1:0]        duration_reg, duration_next;
    logic [AW-1:0]            hint_reg, hint_next;
    logic                     out_valid_reg, out_valid_next;
    kts_out_t                 out_data_reg, out_data_next;
    logic [TIME_W-1:0]        t_reg, t_next;
    logic [TIME_W-1:0]        ta_reg, ta_next;
    logic [TIME_W-1:0]        tb_reg, tb_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [AW-1:0]            i0_reg, i0_next;
    logic [AW-1:0]            i1_reg, i1_next;
    kts_key_t                 a_reg, a_next;
    kts_key_t                 b_reg, b_next;
    logic [TIME_W:0]          num_reg, num_next;
    logic [TIME_W:0]          den_reg, den_next;
    logic [TIME_W-1:0]        an_reg, an_next;
    logic [TIME_W-1:0]        ad_reg, ad_next;
    logic                     zero_reg, zero_next;
    logic [BLEND_W-1:0]       f_reg, f_next;
    logic                     empty_reg, empty_next;
    logic                     single_reg, single_next;

    logic [CNT_W-1:0]         n_keys;
    logic [CNT_W-1:0]         last;
    logic [CNT_W-1:0]         h_ext;
    logic                     h_lt_last;
    logic                     h1_lt_last;
    logic [CNT_W-1:0]         mid_calc;
    logic [CNT_W-1:0]         i0_p1;
    logic                     accept;
    logic                     is_sample;
    logic                     slot_ok;
    logic                     first_hit;
    logic                     second_hit;
    logic                     below_mid;
    logic                     out_free;
    logic                     frac_needed;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    kts_key_t                 mem_wdata;
    logic [AW-1:0]            mem_raddr;
    kts_key_t                 mem_rdata;
    kts_div_req_t             div_req;
    kts_div_rsp_t             div_rsp;
    logic                     mix_start;
    kts_mix_rsp_t             mix_rsp;

    // effective key count, saturated to the store depth
    assign n_keys = (CMP_W'(key_count_reg) > CMP_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                             : CNT_W'(key_count_reg);
    assign last   = n_keys - CNT_W'(1);

    // hint and search conditions
    assign h_ext       = CNT_W'(hint_reg);
    assign h_lt_last   = h_ext < last;
    assign h1_lt_last  = (h_ext + CNT_W'(1)) < last;
    assign first_hit   = (ta_reg <= t_reg) && (t_reg < mem_rdata.key_time);
    assign second_hit  = (tb_reg <= t_reg) && (t_reg < mem_rdata.key_time);
    assign below_mid   = t_reg < mem_rdata.key_time;
    assign mid_calc    = lo_reg + (cnt_reg >> 1);
    assign i0_p1       = CNT_W'(i0_reg) + CNT_W'(1);
    assign frac_needed = !zero_reg && (an_reg < ad_reg);

    // handshakes
    assign accept    = in_valid && in_ready;
    assign is_sample = in_data.mode == MODE_SAMPLE;
    assign slot_ok   = SLOTC_W'(in_data.key_index) < SLOTC_W'(MAX_KEYS);
    assign out_free  = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    if (n_keys == '0)
                        state_next = ST_DONE;
                    else if (n_keys == CNT_W'(1))
                        state_next = ST_SINGLE;
                    else if (duration_reg != '0)
                        state_next = ST_MOD_GO;
                    else
                        state_next = ST_HINT0;
                end
            end
            ST_SINGLE:     state_next = ST_DONE;
            ST_MOD_GO:     state_next = ST_MOD_WAIT;
            ST_MOD_WAIT:   state_next = div_rsp.done ? ST_HINT0 : ST_MOD_WAIT;
            ST_HINT0:      state_next = h_lt_last ? ST_HINT1 : ST_SRCH_ISSUE;
            ST_HINT1:      state_next = ST_HINT2;
            ST_HINT2:
            begin
                if (first_hit)
                    state_next = ST_RD0;
                else if (h1_lt_last)
                    state_next = ST_HINT3;
                else
                    state_next = ST_SRCH_ISSUE;
            end
            ST_HINT3:      state_next = second_hit ? ST_RD0 : ST_SRCH_ISSUE;
            ST_SRCH_ISSUE: state_next = (cnt_reg == '0) ? ST_RESOLVE : ST_SRCH_CMP;
            ST_SRCH_CMP:   state_next = ST_SRCH_ISSUE;
            ST_RESOLVE:    state_next = ST_RD0;
            ST_RD0:        state_next = ST_RD1;
            ST_RD1:        state_next = ST_RD2;
            ST_RD2:        state_next = ST_DIFF;
            ST_DIFF:       state_next = ST_ABS;
            ST_ABS:        state_next = ST_BLEND;
            ST_BLEND:      state_next = frac_needed ? ST_DIV_WAIT : ST_MIX_GO;
            ST_DIV_WAIT:   state_next = div_rsp.done ? ST_MIX_GO : ST_DIV_WAIT;
            ST_MIX_GO:     state_next = ST_MIX_WAIT;
            ST_MIX_WAIT:   state_next = mix_rsp.done ? ST_DONE : ST_MIX_WAIT;
            ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake, memory ports, unit requests
    always_comb
    begin
        in_ready  = state_reg == ST_IDLE;
        mem_we    = accept && !is_sample && slot_ok;
        mem_waddr = AW'(in_data.key_index);
        mem_wdata.key_time = in_data.time_req;
        mem_wdata.val_x    = in_data.value_x;
        mem_wdata.val_y    = in_data.value_y;
        mem_wdata.val_z    = in_data.value_z;
        mem_raddr = '0;
        div_req   = '0;
        mix_start = 1'b0;
        case (state_reg)
            ST_HINT0:      mem_raddr = hint_reg;
            ST_HINT1:      mem_raddr = AW'(h_ext + CNT_W'(1));
            ST_HINT2:      mem_raddr = AW'(h_ext + CNT_W'(2));
            ST_SRCH_ISSUE: mem_raddr = AW'(mid_calc);
            ST_RD0:        mem_raddr = i0_reg;
            ST_RD1:        mem_raddr = i1_reg;
            ST_MOD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = DIV_STEPS_MOD;
                div_req.rem_init = '0;
                div_req.quo_init = t_reg;
                div_req.divisor  = duration_reg;
            end
            ST_BLEND:
            begin
                div_req.start    = frac_needed;
                div_req.steps    = DIV_STEPS_FRAC;
                div_req.rem_init = an_reg;
                div_req.quo_init = '0;
                div_req.divisor  = ad_reg;
            end
            ST_MIX_GO:     mix_start = 1'b1;
            default:       mem_raddr = '0;
        endcase
    end

    // datapath next values
    always_comb
    begin
        key_count_next = key_count_reg;
        duration_next  = duration_reg;
        hint_next      = hint_reg;
        t_next         = t_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        mid_next       = mid_reg;
        i0_next        = i0_reg;
        i1_next        = i1_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        an_next        = an_reg;
        ad_next        = ad_reg;
        zero_next      = zero_reg;
        f_next         = f_reg;
        empty_next     = empty_reg;
        single_next    = single_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_COUNT: key_count_next = cfg_wdata[KEY_COUNT_W-1:0];
                REG_DURATION:  duration_next  = cfg_wdata[TIME_W-1:0];
                default:       duration_next  = duration_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    t_next      = in_data.time_req;
                    empty_next  = n_keys == '0;
                    single_next = n_keys == CNT_W'(1);
                    if (!is_sample)
                        hint_next = '0;
                end
            end
            ST_SINGLE:   a_next = mem_rdata;
            ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                    t_next = div_rsp.remainder;
            end
            ST_HINT0:
            begin
                lo_next  = '0;
                cnt_next = n_keys;
            end
            ST_HINT1:    ta_next = mem_rdata.key_time;
            ST_HINT2:
            begin
                tb_next = mem_rdata.key_time;
                if (first_hit)
                    i0_next = hint_reg;
            end
            ST_HINT3:
            begin
                if (second_hit)
                begin
                    i0_next   = AW'(h_ext + CNT_W'(1));
                    hint_next = AW'(h_ext + CNT_W'(1));
                end
            end
            ST_SRCH_ISSUE: mid_next = mid_calc;
            ST_SRCH_CMP:
            begin
                if (below_mid)
                begin
                    cnt_next = cnt_reg >> 1;
                end
                else
                begin
                    lo_next  = mid_reg + CNT_W'(1);
                    cnt_next = cnt_reg - (cnt_reg >> 1) - CNT_W'(1);
                end
            end
            ST_RESOLVE:
            begin
                if (lo_reg == '0)
                    i0_next = '0;
                else if (lo_reg >= n_keys)
                    i0_next = AW'(last);
                else
                    i0_next = AW'(lo_reg - CNT_W'(1));
                hint_next = i0_next;
            end
            ST_RD0:      i1_next = (i0_p1 == n_keys) ? '0 : AW'(i0_p1);
            ST_RD1:      a_next = mem_rdata;
            ST_RD2:      b_next = mem_rdata;
            ST_DIFF:
            begin
                num_next = {1'b0, t_reg} - {1'b0, a_reg.key_time};
                den_next = {1'b0, b_reg.key_time} - {1'b0, a_reg.key_time};
            end
            ST_ABS:
            begin
                zero_next = (den_reg == '0) || (num_reg == '0)
                            || (num_reg[TIME_W] != den_reg[TIME_W]);
                an_next   = num_reg[TIME_W] ? TIME_W'(-num_reg) : num_reg[TIME_W-1:0];
                ad_next   = den_reg[TIME_W] ? TIME_W'(-den_reg) : den_reg[TIME_W-1:0];
            end
            ST_BLEND:
            begin
                if (zero_reg)
                    f_next = '0;
                else if (an_reg >= ad_reg)
                    f_next = BLEND_ONE;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    f_next = {1'b0, div_rsp.quotient[FRAC_W-1:0]};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        out_data_next             = '0;
                        out_data_next.empty_track = 1'b1;
                    end
                    else if (single_reg)
                    begin
                        out_data_next       = '0;
                        out_data_next.out_x = a_reg.val_x;
                        out_data_next.out_y = a_reg.val_y;
                        out_data_next.out_z = a_reg.val_z;
                    end
                    else
                    begin
                        out_data_next.out_x       = mix_rsp.res_x;
                        out_data_next.out_y       = mix_rsp.res_y;
                        out_data_next.out_z       = mix_rsp.res_z;
                        out_data_next.lower_key   = LOWER_W'(i0_reg);
                        out_data_next.blend       = f_reg;
                        out_data_next.empty_track = 1'b0;
                    end
                end
            end
            default:     t_next = t_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_count_reg <= '0;
            duration_reg  <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            duration_reg  <= duration_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        t_reg        <= t_next;
        ta_reg       <= ta_next;
        tb_reg       <= tb_next;
        lo_reg       <= lo_next;
        cnt_reg      <= cnt_next;
        mid_reg      <= mid_next;
        i0_reg       <= i0_next;
        i1_reg       <= i1_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        an_reg       <= an_next;
        ad_reg       <= ad_next;
        zero_reg     <= zero_next;
        f_reg        <= f_next;
        empty_reg    <= empty_next;
        single_reg   <= single_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // key store
    kts_key_mem #(
        .MAX_KEYS (MAX_KEYS)
    ) u_key_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared divider for time wrap and blend factor
    kts_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // component mixer
    kts_mix_unit u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .key_a  (a_reg),
        .key_b  (b_reg),
        .factor (f_reg),
        .rsp    (mix_rsp)
    );

endmodule

[hw/rtl/kts_checker.sv]
// port-level checks for keyframe_track_sampler_unit, bound to the top level
// depends on kts_pkg and keyframe_track_sampler_unit_defines.svh
`timescale 1ns / 1ps
`include "keyframe_track_sampler_unit_defines.svh"

module kts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input kts_pkg::kts_in_t    in_data,
    input logic                out_valid,
    input logic                out_ready,
    input kts_pkg::kts_out_t   out_data
);
    import kts_pkg::*;

    // a stalled result item holds
    `KTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

    // an empty-track result carries all zero fields
    `KTS_ASSERT_NOW(a_empty_zero, out_valid && out_data.empty_track, (out_data.out_x == 0) && (out_data.out_y == 0) && (out_data.out_z == 0) && (out_data.lower_key == 0) && (out_data.blend == 0), "empty track result not zero")

    // blend factor never exceeds one
    `KTS_ASSERT_NOW(a_blend_range, out_valid, out_data.blend <= BLEND_ONE, "blend factor above one")

    // a sample item occupies the block on the next cycle
    `KTS_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (in_data.mode == MODE_SAMPLE), !in_ready, "ready right after a sample item")

    // a load item leaves the block ready on the next cycle
    `KTS_ASSERT_NEXT(a_load_quick, in_valid && in_ready && (in_data.mode == MODE_LOAD), in_ready, "not ready right after a load item")

endmodule

bind keyframe_track_sampler_unit kts_checker u_kts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
